/* design/cqs_pkg.sv */
// Shared constants, types and a helper function for the circular queue with search.
`timescale 1ns / 1ps

package cqs_pkg;

	// Ring geometry: DEPTH slots, one always left empty.
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VAL_W = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic signed [VAL_W-1:0] val_t;

	// Request codes.
	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_DEQ  = 2'd1;
	localparam logic [1:0] REQ_SRCH = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

	// One result item as it travels from the sequencer to the output register.
	typedef struct packed {
		logic [1:0] status;
		logic       found;
		val_t       front_value;
		val_t       back_value;
		logic       is_empty;
		logic       is_full;
	} res_t;

	// Advance a ring index by one slot, wrapping at DEPTH.
	function automatic idx_t idx_next(input idx_t i);
		idx_t r;
		if (i == idx_t'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + idx_t'(1);
		end
		return r;
	endfunction

endpackage

/* design/cqs_ram.sv */
// Simple dual-port synchronous RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module cqs_ram #(
	parameter int RAM_DEPTH = 16,
	parameter int RAM_WIDTH = 32,
	parameter int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  logic [RAM_WIDTH-1:0] wdata,
	input  logic [ADDR_W-1:0]    raddr,
	output logic [RAM_WIDTH-1:0] rdata
);

	logic [RAM_WIDTH-1:0] mem [RAM_DEPTH];
	logic [RAM_WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/cqs_ctrl.sv */
// Sequencer that keeps the ring indices and runs enqueue, dequeue and search.
`timescale 1ns / 1ps

module cqs_ctrl import cqs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  val_t       value,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res,
	output logic       mem_we,
	output idx_t       mem_waddr,
	output val_t       mem_wdata,
	output idx_t       mem_raddr,
	input  val_t       mem_rdata
);

	state_t     state_q;
	idx_t       head_q;
	idx_t       tail_q;
	idx_t       ptr_q;
	val_t       val_q;
	val_t       front_q;
	val_t       back_q;
	logic [1:0] status_q;
	logic       found_q;

	logic in_fire;
	logic ring_empty;
	logic ring_full;
	idx_t head_nxt;
	idx_t ptr_nxt;

	assign in_fire    = in_valid && in_ready;
	assign ring_empty = (head_q == tail_q);
	assign ring_full  = (idx_next(tail_q) == head_q);
	assign head_nxt   = idx_next(head_q);
	assign ptr_nxt    = idx_next(ptr_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);

	// Memory write: an accepted enqueue on a ring that is not full.
	assign mem_we    = in_fire && (req_type == REQ_ENQ) && !ring_full;
	assign mem_waddr = tail_q;
	assign mem_wdata = value;

	// Memory read: the next scan slot, the new head for a dequeue, else the head.
	always_comb begin
		if (state_q == ST_SCAN) begin
			mem_raddr = ptr_nxt;
		end else if (req_type == REQ_DEQ) begin
			mem_raddr = head_nxt;
		end else begin
			mem_raddr = head_q;
		end
	end

	// Control state and ring indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (req_type)
							REQ_ENQ: begin
								if (!ring_full) begin
									tail_q <= idx_next(tail_q);
								end
								state_q <= ST_RESP;
							end
							REQ_DEQ: begin
								if (ring_empty) begin
									state_q <= ST_RESP;
								end else begin
									head_q <= head_nxt;
									state_q <= (head_nxt == tail_q) ? ST_RESP : ST_FETCH;
								end
							end
							REQ_SRCH: begin
								state_q <= ring_empty ? ST_RESP : ST_SCAN;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					if ((mem_rdata == val_q) || (ptr_nxt == tail_q)) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request value, scan pointer, cached front and back, result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					val_q    <= value;
					ptr_q    <= head_q;
					found_q  <= 1'b0;
					status_q <= STAT_DONE;
					case (req_type)
						REQ_ENQ: begin
							if (ring_full) begin
								status_q <= STAT_FULL;
							end else begin
								back_q <= value;
								if (ring_empty) begin
									front_q <= value;
								end
							end
						end
						REQ_DEQ: begin
							if (ring_empty) begin
								status_q <= STAT_EMPTY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_FETCH: begin
				front_q <= mem_rdata;
			end
			ST_SCAN: begin
				if (mem_rdata == val_q) begin
					found_q <= 1'b1;
				end else begin
					ptr_q <= ptr_nxt;
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields; front and back read as zero on an empty ring.
	always_comb begin
		res.status      = status_q;
		res.found       = found_q;
		res.front_value = ring_empty ? val_t'(0) : front_q;
		res.back_value  = ring_empty ? val_t'(0) : back_q;
		res.is_empty    = ring_empty;
		res.is_full     = ring_full;
	end

	// The block never takes an item while a result is pending.
	a_no_accept_in_resp: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && res_valid))
		else $error("input ready while a result is pending");

	// An accepted item closes the input side on the next cycle.
	a_accept_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input still ready after an accepted item");

	// The tail moves only on an accepted enqueue.
	a_tail_moves_on_enq: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && (req_type == REQ_ENQ)) |=> $stable(tail_q))
		else $error("tail moved without an enqueue");

	// The head moves only on an accepted dequeue.
	a_head_moves_on_deq: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && (req_type == REQ_DEQ)) |=> $stable(head_q))
		else $error("head moved without a dequeue");

	// A scan never reaches the tail slot.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (ptr_q != tail_q))
		else $error("scan pointer reached the tail");

endmodule

/* design/circular_queue_with_search.sv */
// Top level of the circular queue with search: sequencer, entry memory and output register.
`timescale 1ns / 1ps

// Usage:
// Requests come in on the input channel (in_valid, in_ready, req_type, value):
// enqueue, dequeue or search. Each request gives exactly one result item on
// the output channel (out_valid, out_ready, status, found, front_value,
// back_value, is_empty, is_full), in request order.
// The ring holds up to DEPTH-1 values in a synchronous entry memory; front
// and back values are kept in registers beside it.
// Steps per item while the output register is free: an enqueue, a rejected
// enqueue, an empty dequeue or an empty search goes straight to its result;
// a dequeue that leaves entries first does one memory read to fetch the new front
// value; a search compares one entry per cycle, set by the single memory read
// port that the scan walks head to tail.
// The next item is accepted the cycle after the result moves into the
// output register, so it can be taken while that result waits there.
// Reset empties the ring: head and tail go to zero and no result is pending.
// When the receiver stalls, the result holds in the output register and the
// sequencer holds the following result; input is then refused.

module circular_queue_with_search import cqs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  val_t       value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic       found,
	output val_t       front_value,
	output val_t       back_value,
	output logic       is_empty,
	output logic       is_full
);

	logic res_valid;
	logic res_ready;
	res_t res;
	logic mem_we;
	idx_t mem_waddr;
	val_t mem_wdata;
	idx_t mem_raddr;
	val_t mem_rdata;
	logic out_valid_q;
	res_t out_q;

	cqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.value     (value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	cqs_ram #(
		.RAM_DEPTH (DEPTH),
		.RAM_WIDTH (VAL_W),
		.ADDR_W    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register takes a result when empty or being drained.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign found       = out_q.found;
	assign front_value = out_q.front_value;
	assign back_value  = out_q.back_value;
	assign is_empty    = out_q.is_empty;
	assign is_full     = out_q.is_full;

endmodule
